### hw/rtl/sha1_pkg.sv
// package: transaction types, constants and round helpers for the sha-1 engine
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha1_out_t;

    // command handed from the front part to the back part
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha1_cmd_t;

    localparam int CmdFifoDepth = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [5:0] LenStartPos = 6'd56;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // round function and constant by round number
    function automatic logic [63:0] round_fk(input logic [6:0] rnd, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        logic [31:0] k;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
            k = K0;
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
            k = K1;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
        end else begin
            f = b ^ c ^ d;
            k = K3;
        end
        round_fk = {f, k};
    endfunction

endpackage

### hw/rtl/sha1_cmd_fifo.sv
// small command queue between the front and the back part
module sha1_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  sha1_pkg::sha1_cmd_t wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output sha1_pkg::sha1_cmd_t rd_data
);
    import sha1_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha1_cmd_t        mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;

    // pointer and count update
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (do_wr) begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd) begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/sha1_front.sv
// front part: takes input transactions and drops those that do nothing
module sha1_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  sha1_pkg::sha1_in_t  s_data,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output sha1_pkg::sha1_cmd_t cmd_data
);
    import sha1_pkg::*;

    logic useful;

    // an item with no byte and no end changes nothing
    assign useful    = s_data.byte_present | s_data.end_of_message;
    assign cmd_valid = s_valid & useful;
    assign s_ready   = cmd_ready | ~useful;
    assign cmd_data  = '{data_byte: s_data.data_byte,
                         byte_present: s_data.byte_present,
                         end_of_message: s_data.end_of_message};

endmodule

### hw/rtl/sha1_core.sv
// back part: block buffer, padding sequencer, round engine and digest output
module sha1_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  sha1_pkg::sha1_cmd_t cmd_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sha1_pkg::sha1_out_t m_data
);
    import sha1_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD80 = 6'b000010,
        ST_PADZ  = 6'b000100,
        ST_LEN   = 6'b001000,
        ST_RND   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    state_t       ret_reg, ret_next;
    logic [31:0]  h_reg [5];
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [63:0]  len_reg;
    logic [6:0]   rnd_reg;
    logic [2:0]   ocnt_reg;
    logic         fin_reg, fin_next;

    logic         push;
    logic [7:0]   push_byte;
    logic         start_rnd;
    logic [31:0]  wnew, wcur, t_val;
    logic [63:0]  fk;

    assign cmd_ready = (state_reg == ST_IDLE);

    // byte to push this cycle
    always_comb begin
        push      = 1'b0;
        push_byte = cmd_data.data_byte;
        case (state_reg)
            ST_IDLE: begin
                push = cmd_valid & cmd_data.byte_present;
            end
            ST_PAD80: begin
                push = 1'b1;
                push_byte = 8'h80;
            end
            ST_PADZ: begin
                push = (fill_reg != LenStartPos);
                push_byte = 8'h00;
            end
            ST_LEN: begin
                push = 1'b1;
                push_byte = len_reg[63:56];
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    assign start_rnd = push & (fill_reg == 6'd63);

    // message schedule and round datapath
    assign wcur  = w_reg[0];
    assign wnew  = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    assign fk    = round_fk(rnd_reg, b_reg, c_reg, d_reg);
    assign t_val = rotl(a_reg, 5) + fk[63:32] + e_reg + fk[31:0] + wcur;

    // sequencer
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = push ? fill_reg + 6'd1 : fill_reg;
        bits_next  = bits_reg;
        fin_next   = fin_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd_data.byte_present) begin
                        bits_next = bits_reg + 64'd8;
                    end
                    fin_next = cmd_data.end_of_message;
                    if (start_rnd) begin
                        state_next = ST_RND;
                        ret_next = cmd_data.end_of_message ? ST_PAD80 : ST_IDLE;
                    end else if (cmd_data.end_of_message) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                state_next = start_rnd ? ST_RND : ST_PADZ;
                ret_next = ST_PADZ;
            end
            ST_PADZ: begin
                if (fill_reg == LenStartPos) begin
                    state_next = ST_LEN;
                end else if (start_rnd) begin
                    state_next = ST_RND;
                    ret_next = ST_PADZ;
                end
            end
            ST_LEN: begin
                if (start_rnd) begin
                    state_next = ST_RND;
                    ret_next = ST_OUT;
                end
            end
            ST_RND: begin
                if (rnd_reg == 7'd79) begin
                    state_next = ret_reg;
                end
            end
            ST_OUT: begin
                if (m_ready && ocnt_reg == 3'd4) begin
                    state_next = ST_IDLE;
                    bits_next = '0;
                    fill_next = '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            fin_reg   <= 1'b0;
            rnd_reg   <= '0;
            ocnt_reg  <= '0;
            h_reg[0]  <= H0;
            h_reg[1]  <= H1;
            h_reg[2]  <= H2;
            h_reg[3]  <= H3;
            h_reg[4]  <= H4;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            fin_reg   <= fin_next;
            rnd_reg   <= (state_reg == ST_RND) ? rnd_reg + 7'd1 : '0;
            if (state_reg == ST_RND && rnd_reg == 7'd79) begin
                h_reg[0] <= h_reg[0] + t_val;
                h_reg[1] <= h_reg[1] + a_reg;
                h_reg[2] <= h_reg[2] + rotl(b_reg, 30);
                h_reg[3] <= h_reg[3] + c_reg;
                h_reg[4] <= h_reg[4] + d_reg;
            end
            if (state_reg == ST_OUT && m_ready) begin
                ocnt_reg <= (ocnt_reg == 3'd4) ? 3'd0 : ocnt_reg + 3'd1;
                if (ocnt_reg == 3'd4) begin
                    h_reg[0] <= H0;
                    h_reg[1] <= H1;
                    h_reg[2] <= H2;
                    h_reg[3] <= H3;
                    h_reg[4] <= H4;
                end
            end
        end
    end

    // word shift line: bytes enter at the tail, rounds shift it and feed in the next schedule word
    always_ff @(posedge aclk) begin
        if (push) begin
            w_reg[15] <= {w_reg[15][23:0], push_byte};
            if (fill_reg[1:0] == 2'd0) begin
                for (int i = 0; i < 15; i++) begin
                    w_reg[i] <= w_reg[i+1];
                end
            end
        end else if (state_reg == ST_RND) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
        end
    end

    // working variables and length capture
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RND) begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end else begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        if (state_reg == ST_PAD80) begin
            len_reg <= bits_reg;
        end else if (state_reg == ST_LEN) begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
    end

    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = '{digest_word: h_reg[ocnt_reg],
                       word_index: ocnt_reg,
                       last_word: (ocnt_reg == 3'd4) & fin_reg};

endmodule

### hw/rtl/sha1_hash_engine_top.sv
// top level of the sha-1 hash engine
//
// s_ channel: one transaction carries an optional message byte and an optional
// end-of-message mark; bytes are hashed in arrival order. m_ channel: after an
// end mark, five transactions carry the digest words, most significant first,
// the fifth flagged by last_word. A transaction with neither byte nor end is
// taken and dropped.
// Bytes are accepted one per cycle while the four-entry command queue has
// room; each 64th byte starts the 80-round compression, one round per cycle.
// Finishing a message takes the padding bytes (one per cycle, up to 64 + 8)
// plus one or two compressions before the first digest word appears.
// When the receiver stalls, the digest words wait and the queue fills; the
// input then stalls too. Reset (aresetn low, synchronous) empties the queue,
// restores the initial chaining value and zeroes the length and fill count.
module sha1_hash_engine_top #(
    parameter int CMD_FIFO_DEPTH = sha1_pkg::CmdFifoDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sha1_pkg::sha1_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sha1_pkg::sha1_out_t m_data
);
    import sha1_pkg::*;

    sha1_cmd_t f_cmd, b_cmd;
    logic      f_valid, f_ready, b_valid, b_ready;

    sha1_front u_front (
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cmd_valid(f_valid),
        .cmd_ready(f_ready),
        .cmd_data (f_cmd)
    );

    sha1_cmd_fifo #(.DEPTH(CMD_FIFO_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(f_valid),
        .wr_ready(f_ready),
        .wr_data (f_cmd),
        .rd_valid(b_valid),
        .rd_ready(b_ready),
        .rd_data (b_cmd)
    );

    sha1_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(b_valid),
        .cmd_ready(b_ready),
        .cmd_data (b_cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### tb/tb_sha1_hash_engine_top.sv
// testbench for the sha-1 hash engine: byte stream in, digest words out, checked
module tb_sha1_hash_engine_top;
    import sha1_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    sha1_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sha1_out_t m_data;

    sha1_hash_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // predictor state
    logic [31:0] hash_state[5];
    logic [7:0]  msg_block[64];
    int unsigned block_fill;
    logic [63:0] msg_len_bits;

    sha1_in_t  byte_queue[$];
    sha1_out_t digest_queue[$];
    int  mismatch_count = 0;
    int  digest_words_seen = 0;
    int  messages_sent = 0;
    bit  stimulus_done = 1'b0;
    bit  quiet_phase = 1'b0;
    int  idle_cycles = 0;

    function automatic logic [31:0] rol32(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void hash_restart();
        hash_state[0] = 32'h67452301; hash_state[1] = 32'hEFCDAB89;
        hash_state[2] = 32'h98BADCFE; hash_state[3] = 32'h10325476;
        hash_state[4] = 32'hC3D2E1F0;
        block_fill = 0;
        msg_len_bits = '0;
    endfunction

    function automatic void hash_compress();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
        d = hash_state[3]; e = hash_state[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol32(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol32(b, 30); b = a; a = t;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
        hash_state[3] += d; hash_state[4] += e;
    endfunction

    function automatic void block_append(logic [7:0] v);
        msg_block[block_fill] = v;
        block_fill++;
        if (block_fill == 64) begin
            hash_compress();
            block_fill = 0;
        end
    endfunction

    // model one accepted transaction, queue any digest words
    function automatic void hash_accept(sha1_in_t it);
        logic [63:0] len;
        sha1_out_t o;
        if (it.byte_present) begin
            msg_len_bits += 64'd8;
            block_append(it.data_byte);
        end
        if (!it.end_of_message) return;
        len = msg_len_bits;
        block_append(8'h80);
        while (block_fill != 56) block_append(8'h00);
        for (int i = 0; i < 8; i++) block_append(len[63 - 8*i -: 8]);
        for (int i = 0; i < 5; i++) begin
            o.digest_word = hash_state[i];
            o.word_index = 3'(i);
            o.last_word = (i == 4);
            digest_queue.push_back(o);
        end
        hash_restart();
    endfunction

    function automatic void push_item(logic [7:0] v, bit pres, bit fin);
        sha1_in_t it;
        it.data_byte = v; it.byte_present = pres; it.end_of_message = fin;
        byte_queue.push_back(it);
    endfunction

    // a message of n random bytes with occasional noise items, ending on a byte or on a bare end
    function automatic void push_message(int n, bit end_on_byte);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, end_on_byte && (i == n - 1));
        end
        if (!end_on_byte || n == 0) push_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    // accept tracking and model update at the rising edge
    bit s_ready_seen = 1'b0;
    always @(posedge aclk) begin
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            hash_accept(s_data);
        end
    end

    // driver: source side with random idle bursts
    int src_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    s_data <= byte_queue.pop_front();
                    s_valid <= 1'b1;
                    if (!quiet_phase && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall bursts
    int sink_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
                sink_gap <= $urandom_range(1, 19);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: compare each digest transaction with the oldest expectation
    always @(posedge aclk) begin
        sha1_out_t want;
        if (aresetn && m_valid && m_ready) begin
            digest_words_seen++;
            if (digest_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected digest word %h idx %0d", m_data.digest_word,
                             m_data.word_index);
            end else begin
                want = digest_queue.pop_front();
                if (m_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 want.digest_word, want.word_index, want.last_word,
                                 m_data.digest_word, m_data.word_index, m_data.last_word);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else if (byte_queue.size() > 0 || s_valid || digest_queue.size() > 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n;
        hash_restart();
        for (int i = 0; i < 64; i++) msg_block[i] = '0;
        // directed: empty message, "abc", noise item, field extremes
        push_item(8'hFF, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hFF, 1'b1, 1'b0);
        push_item(8'hFF, 1'b0, 1'b1);
        push_item(8'h55, 1'b1, 1'b0);
        push_item(8'hAA, 1'b1, 1'b1);
        messages_sent = 5;
        // random messages, many near padding boundaries (55, 56, 63, 64 bytes)
        while (byte_queue.size() < 300) begin
            case ($urandom_range(0, 5))
                0: n = $urandom_range(54, 57);
                1: n = $urandom_range(62, 65);
                2: n = $urandom_range(118, 130);
                default: n = $urandom_range(0, 20);
            endcase
            if (n > 320 - byte_queue.size()) n = 320 - byte_queue.size();
            push_message(n, $urandom_range(0, 1));
            messages_sent++;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        wait (byte_queue.size() < 80);
        quiet_phase = 1'b1;
        wait (byte_queue.size() == 0 && !s_valid);
        wait (digest_queue.size() == 0);
        repeat (300) @(posedge aclk);
        $display("covered %0d messages, %0d digest words checked, %0d mismatches",
                 messages_sent, digest_words_seen, mismatch_count);
        $display("includes empty message, padding boundary lengths and multi-block messages");
        if (mismatch_count == 0 && digest_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
